// ===== hw/rtl/rpmf_pkg.sv =====
// rpmf_pkg: shared types and constants of the radar pulse matched filter
// used by rpmf_front, rpmf_back and the top level; depends on nothing

package rpmf_pkg;

  // fixed field and register widths
  localparam int TAP_COUNT_W = 7;
  localparam int RANGE_W     = 16;
  localparam int TAP_IDX_W   = 6;
  localparam int OUT_W       = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // defaults for the top-level parameters
  localparam int DEF_MAX_TAPS    = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd64;
  localparam logic [RANGE_W-1:0]     RANGE_LEN_RST = 16'd1024;

  // input request kinds
  typedef enum logic {
    REQ_TAP    = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 2'd0,
    REG_RANGE_LEN = 2'd1
  } reg_idx_e;

  // classified command handed from front to back
  typedef struct packed {
    logic               is_sample;
    logic               has_bins;
    logic               last;
    logic [RANGE_W-1:0] top;
    logic [RANGE_W-1:0] n_first;
    logic [RANGE_W-1:0] n_last;
  } cmd_t;

endpackage

// ===== hw/rtl/rpmf_ram.sv =====
// rpmf_ram: generic single write port, single read port ram
// registered read data; no dependencies

module rpmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rpmf_front.sv =====
// rpmf_front: accepts input beats, tracks the line position and classifies
// each beat into a command for the back end; uses rpmf_pkg

module rpmf_front #(
  parameter int MAX_TAPS    = rpmf_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = rpmf_pkg::DEF_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_TAPS),
  localparam int TW = $clog2(MAX_TAPS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [rpmf_pkg::TAP_IDX_W-1:0]      tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_real_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_imag_i,
  // configuration
  input  logic [TW-1:0]                       lag_i,
  input  logic [rpmf_pkg::RANGE_W-1:0]        range_len_i,
  // queue side
  input  logic                                full_i,
  output logic                                push_o,
  output rpmf_pkg::cmd_t                      cmd_o,
  output logic [AW-1:0]                       addr_o,
  output logic signed [SAMPLE_BITS-1:0]       real_o,
  output logic signed [SAMPLE_BITS-1:0]       imag_o
);

  logic [rpmf_pkg::RANGE_W-1:0] pos_q;
  logic [AW-1:0]                wp_q;
  logic                         accept;
  logic                         is_sample;
  logic                         tap_ok;
  logic [rpmf_pkg::RANGE_W-1:0] len_eff;
  logic [rpmf_pkg::RANGE_W-1:0] lag_ext;
  logic                         last;
  logic                         has_normal;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_sample  = (req_type_i == rpmf_pkg::REQ_SAMPLE);
  assign tap_ok     = (32'(tap_index_i) < MAX_TAPS);

  // line bookkeeping for a sample beat
  assign len_eff    = (range_len_i == '0) ? 16'd1 : range_len_i;
  assign lag_ext    = 16'(lag_i);
  assign last       = ((17'(pos_q) + 17'd1) >= 17'(len_eff));
  assign has_normal = (pos_q >= lag_ext);

  // command build
  always_comb begin
    cmd_o.is_sample = is_sample;
    cmd_o.has_bins  = has_normal || last;
    cmd_o.last      = last;
    cmd_o.top       = pos_q;
    cmd_o.n_first   = has_normal ? (pos_q - lag_ext) : '0;
    cmd_o.n_last    = last ? pos_q : (pos_q - lag_ext);
  end

  assign addr_o = is_sample ? wp_q : AW'(tap_index_i);
  assign real_o = in_real_i;
  assign imag_o = in_imag_i;
  // taps beyond the store are dropped here
  assign push_o = accept && (is_sample || tap_ok);

  // sample position and ring write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      wp_q  <= '0;
    end else if (accept && is_sample) begin
      if (last) begin
        pos_q <= '0;
        wp_q  <= '0;
      end else begin
        pos_q <= pos_q + 16'd1;
        wp_q  <= (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rpmf_queue.sv =====
// rpmf_queue: short flip-flop fifo that decouples front and back
// no dependencies

module rpmf_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rpmf_back.sv =====
// rpmf_back: executes queued commands; tap and sample stores plus one shared
// complex multiply-accumulate that walks the taps of each output bin
// uses rpmf_pkg and rpmf_ram

module rpmf_back #(
  parameter int MAX_TAPS    = rpmf_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = rpmf_pkg::DEF_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_TAPS),
  localparam int TW = $clog2(MAX_TAPS + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // queue side
  input  logic                                  q_valid_i,
  output logic                                  q_pop_o,
  input  rpmf_pkg::cmd_t                        q_cmd_i,
  input  logic [AW-1:0]                         q_addr_i,
  input  logic signed [SAMPLE_BITS-1:0]         q_real_i,
  input  logic signed [SAMPLE_BITS-1:0]         q_imag_i,
  // configuration
  input  logic [TW-1:0]                         taps_i,
  input  logic [TW-1:0]                         half_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rpmf_pkg::OUT_W-1:0]     out_real_o,
  output logic signed [rpmf_pkg::OUT_W-1:0]     out_imag_o,
  output logic [rpmf_pkg::RANGE_W-1:0]          range_bin_o,
  output logic                                  line_done_o,
  output logic                                  run_last_o
);

  localparam int DW = AW + 1;
  localparam int SW = 2 * SAMPLE_BITS;
  localparam int PW = 2 * SAMPLE_BITS;
  localparam int OW = rpmf_pkg::OUT_W;
  localparam int XW = (PW + 1 > OW) ? PW + 1 : OW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIN,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                       state_q;
  rpmf_pkg::cmd_t               cmd_q;
  logic [AW-1:0]                top_addr_q;
  logic [rpmf_pkg::RANGE_W-1:0] n_q;
  logic [AW-1:0]                m_q;
  logic signed [DW-1:0]         d_q;
  logic [AW-1:0]                ra_q;
  logic                         s1_q;
  logic                         s2_q;
  logic                         s3_q;
  logic                         out_valid_q;
  logic [OW-1:0]                out_re_q;
  logic [OW-1:0]                out_im_q;
  logic [rpmf_pkg::RANGE_W-1:0] out_bin_q;
  logic                         out_done_q;
  logic                         out_last_q;

  // datapath registers
  logic signed [PW-1:0] p_rr_q;
  logic signed [PW-1:0] p_ii_q;
  logic signed [PW-1:0] p_ri_q;
  logic signed [PW-1:0] p_ir_q;
  logic [OW-1:0]        t_re_q;
  logic [OW-1:0]        t_im_q;
  logic [OW-1:0]        acc_re_q;
  logic [OW-1:0]        acc_im_q;

  logic                 tap_we;
  logic                 smp_we;
  logic [SW-1:0]        wdata;
  logic [SW-1:0]        tap_rdata;
  logic [SW-1:0]        smp_rdata;
  logic signed [SAMPLE_BITS-1:0] tap_re;
  logic signed [SAMPLE_BITS-1:0] tap_im;
  logic signed [SAMPLE_BITS-1:0] smp_re;
  logic signed [SAMPLE_BITS-1:0] smp_im;
  logic signed [XW-1:0] x_rr;
  logic signed [XW-1:0] x_ii;
  logic signed [XW-1:0] x_ri;
  logic signed [XW-1:0] x_ir;
  logic [17:0]          d0_full;
  logic [AW-1:0]        d0;
  logic [DW-1:0]        ra_diff;
  logic [DW-1:0]        ra_wrap;
  logic [AW-1:0]        ra0;
  logic [AW-1:0]        ra_next;
  logic                 lane_ok;
  logic                 last_tap;
  logic                 out_free;
  logic                 bin_last;

  // queue pop and store writes
  assign q_pop_o = q_valid_i && (state_q == ST_IDLE);
  assign tap_we  = q_pop_o && !q_cmd_i.is_sample;
  assign smp_we  = q_pop_o && q_cmd_i.is_sample;
  assign wdata   = {q_real_i, q_imag_i};

  rpmf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (q_addr_i),
    .wdata_i (wdata),
    .raddr_i (m_q),
    .rdata_o (tap_rdata)
  );

  // ring of the newest samples of the line, slot = sample index mod depth
  rpmf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TAPS)
  ) u_smp_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (q_addr_i),
    .wdata_i (wdata),
    .raddr_i (ra_q),
    .rdata_o (smp_rdata)
  );

  // start of a bin: distance of the first tap's sample from the newest one
  assign d0_full = 18'(cmd_q.top) + 18'(half_i) - 18'(n_q) - 18'd1;
  assign d0      = d0_full[AW-1:0];
  assign ra_diff = {1'b0, top_addr_q} - {1'b0, d0};
  assign ra_wrap = ra_diff + DW'(MAX_TAPS);
  assign ra0     = ra_diff[AW] ? ra_wrap[AW-1:0] : ra_diff[AW-1:0];

  // per tap stepping
  assign ra_next  = (ra_q == AW'(MAX_TAPS - 1)) ? '0 : ra_q + 1'b1;
  assign lane_ok  = !d_q[DW-1] && (16'(d_q[AW-1:0]) <= cmd_q.top);
  assign last_tap = (TW'(m_q) == (taps_i - TW'(1)));
  assign out_free = !out_valid_q || !out_stall_i;
  assign bin_last = (n_q == cmd_q.n_last);

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      top_addr_q  <= '0;
      n_q         <= '0;
      m_q         <= '0;
      d_q         <= '0;
      ra_q        <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      s3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_re_q    <= '0;
      out_im_q    <= '0;
      out_bin_q   <= '0;
      out_done_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      s1_q <= (state_q == ST_RUN) && lane_ok;
      s2_q <= s1_q;
      s3_q <= s2_q;
      // a taken beat leaves the output unless a new bin replaces it below
      if (!out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i && q_cmd_i.is_sample && q_cmd_i.has_bins) begin
            cmd_q      <= q_cmd_i;
            top_addr_q <= q_addr_i;
            n_q        <= q_cmd_i.n_first;
            state_q    <= ST_BIN;
          end
        end
        ST_BIN: begin
          m_q     <= '0;
          d_q     <= {1'b0, d0};
          ra_q    <= ra0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          m_q  <= m_q + 1'b1;
          d_q  <= d_q - 1'b1;
          ra_q <= ra_next;
          if (last_tap) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_q && !s2_q && !s3_q) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_re_q    <= acc_re_q;
            out_im_q    <= acc_im_q;
            out_bin_q   <= n_q;
            out_done_q  <= cmd_q.last && (n_q == cmd_q.top);
            out_last_q  <= bin_last;
            if (bin_last) begin
              state_q <= ST_IDLE;
            end else begin
              n_q     <= n_q + 16'd1;
              state_q <= ST_BIN;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // conj(tap) * sample, products then pair sums then accumulate
  assign tap_re = tap_rdata[SW-1:SAMPLE_BITS];
  assign tap_im = tap_rdata[SAMPLE_BITS-1:0];
  assign smp_re = smp_rdata[SW-1:SAMPLE_BITS];
  assign smp_im = smp_rdata[SAMPLE_BITS-1:0];
  assign x_rr   = XW'(p_rr_q);
  assign x_ii   = XW'(p_ii_q);
  assign x_ri   = XW'(p_ri_q);
  assign x_ir   = XW'(p_ir_q);

  always_ff @(posedge clk_i) begin
    p_rr_q <= tap_re * smp_re;
    p_ii_q <= tap_im * smp_im;
    p_ri_q <= tap_re * smp_im;
    p_ir_q <= tap_im * smp_re;
    t_re_q <= x_rr[OW-1:0] + x_ii[OW-1:0];
    t_im_q <= x_ri[OW-1:0] - x_ir[OW-1:0];
    if (state_q == ST_BIN) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (s3_q) begin
      acc_re_q <= acc_re_q + t_re_q;
      acc_im_q <= acc_im_q + t_im_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_real_o  = out_re_q;
  assign out_imag_o  = out_im_q;
  assign range_bin_o = out_bin_q;
  assign line_done_o = out_done_q;
  assign run_last_o  = out_last_q;

  // mac pipeline is empty whenever no bin is being summed
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_q && !s2_q && !s3_q))
    else $error("mac pipeline busy while idle");

  // a bin is only emitted after its last product was added
  a_emit_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!s1_q && !s2_q && !s3_q))
    else $error("bin emitted with products in flight");

  // emitting the final bin of a command returns to idle
  a_last_bin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && bin_last) |=> (state_q == ST_IDLE))
    else $error("sequencer did not finish after last bin");

  // a bin never lies past the newest sample of its line
  a_bin_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (n_q <= cmd_q.top && cmd_q.n_last <= cmd_q.top))
    else $error("bin index beyond newest sample");

endmodule

// ===== hw/rtl/radar_pulse_matched_filter.sv =====
// radar_pulse_matched_filter: top level of the complex pulse compression filter
// holds the configuration registers; uses rpmf_pkg, rpmf_front, rpmf_queue,
// rpmf_back

// Complex matched filter over one range line at a time. Tap beats
// (req_type 0) load the transmitted pulse, sample beats (req_type 1) stream
// range_len received samples; bin n is sum over m of conj(tap[m]) times
// x[n+m+1-ceil((T-1)/2)], exact and wrapped to 40 bits, emitted once sample
// n+floor((T-1)/2)+1 arrives, with the rest of the line flushed on its last
// sample. A four-entry queue sits between the input side and the compute
// side, so beats are taken while results wait. All work runs through one
// complex multiply-accumulate that handles one tap per cycle. The compute side
// pops a queued beat only while idle; each bin runs a setup state, the T
// effective taps, a product pipeline drain and an emit state that waits for a
// free output; flush bins skip taps that fall past the newest sample. The
// line end releases up to floor((T-1)/2)+2 bins. The user is to write the
// configuration only while the block is idle; the block does not enforce it.

module radar_pulse_matched_filter #(
  parameter int MAX_TAPS    = rpmf_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = rpmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rpmf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rpmf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [rpmf_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0]        in_real_i,
  input  logic signed [SAMPLE_BITS-1:0]        in_imag_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rpmf_pkg::OUT_W-1:0]    out_real_o,
  output logic signed [rpmf_pkg::OUT_W-1:0]    out_imag_o,
  output logic [rpmf_pkg::RANGE_W-1:0]         range_bin_o,
  output logic                                 line_done_o,
  output logic                                 run_last_o
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int QW = $bits(rpmf_pkg::cmd_t) + AW + 2 * SAMPLE_BITS;

  logic [rpmf_pkg::TAP_COUNT_W-1:0] tap_count_q;
  logic [rpmf_pkg::RANGE_W-1:0]     range_len_q;
  logic [TW-1:0]                    taps;
  logic [TW-1:0]                    half;
  logic [TW-1:0]                    lag;

  logic                             f_push;
  rpmf_pkg::cmd_t                   f_cmd;
  logic [AW-1:0]                    f_addr;
  logic signed [SAMPLE_BITS-1:0]    f_re;
  logic signed [SAMPLE_BITS-1:0]    f_im;
  logic                             q_full;
  logic                             q_valid;
  logic                             q_pop;
  logic [QW-1:0]                    q_wdata;
  logic [QW-1:0]                    q_rdata;
  rpmf_pkg::cmd_t                   q_cmd;
  logic [AW-1:0]                    q_addr;
  logic signed [SAMPLE_BITS-1:0]    q_re;
  logic signed [SAMPLE_BITS-1:0]    q_im;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= rpmf_pkg::TAP_COUNT_RST;
      range_len_q <= rpmf_pkg::RANGE_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rpmf_pkg::REG_TAP_COUNT: begin
          tap_count_q <= cfg_wdata_i[rpmf_pkg::TAP_COUNT_W-1:0];
        end
        rpmf_pkg::REG_RANGE_LEN: begin
          range_len_q <= cfg_wdata_i[rpmf_pkg::RANGE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective tap count clamped to 2..MAX_TAPS, center offset and lag
  always_comb begin
    if (tap_count_q < rpmf_pkg::TAP_COUNT_W'(2)) begin
      taps = TW'(2);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      taps = TW'(MAX_TAPS);
    end else begin
      taps = TW'(tap_count_q);
    end
  end

  assign half = taps >> 1;
  assign lag  = ((taps - TW'(1)) >> 1) + TW'(1);

  rpmf_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .tap_index_i (tap_index_i),
    .in_real_i   (in_real_i),
    .in_imag_i   (in_imag_i),
    .lag_i       (lag),
    .range_len_i (range_len_q),
    .full_i      (q_full),
    .push_o      (f_push),
    .cmd_o       (f_cmd),
    .addr_o      (f_addr),
    .real_o      (f_re),
    .imag_o      (f_im)
  );

  // command queue between front and back
  assign q_wdata = {f_cmd, f_addr, f_re, f_im};
  assign {q_cmd, q_addr, q_re, q_im} = q_rdata;

  rpmf_queue #(
    .WIDTH (QW),
    .DEPTH (rpmf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  rpmf_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_cmd_i     (q_cmd),
    .q_addr_i    (q_addr),
    .q_real_i    (q_re),
    .q_imag_i    (q_im),
    .taps_i      (taps),
    .half_i      (half),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_real_o  (out_real_o),
    .out_imag_o  (out_imag_o),
    .range_bin_o (range_bin_o),
    .line_done_o (line_done_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== dv/radar_pulse_matched_filter_test.sv =====
// radar_pulse_matched_filter_test: self-checking testbench of the pulse compression filter
// holds a scoreboard class with its own filter predictor, the beat drivers and the run
// depends on rpmf_pkg and radar_pulse_matched_filter only

module radar_pulse_matched_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpmf_pkg::*;

  localparam int MAX_TAPS      = DEF_MAX_TAPS;
  localparam int SAMPLE_W      = DEF_SAMPLE_BITS;
  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int DRAIN_CYCLES  = 200;
  localparam int SETTLE_LIMIT  = 200000;
  localparam int PHASE_ONE_END = 115;
  localparam int PHASE_TWO_END = 230;
  localparam int TOTAL_BEATS   = 330;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 1500;
  localparam int PRINT_CAP     = 100;

  localparam logic signed [SAMPLE_W-1:0] MOST_NEG = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] MOST_POS = 16'sh7FFF;

  // one input beat: a tap load or a received sample
  typedef struct {
    req_type_e                   kind;
    logic [TAP_IDX_W-1:0]        idx;
    logic signed [SAMPLE_W-1:0]  re;
    logic signed [SAMPLE_W-1:0]  im;
  } beat_t;

  // one compressed output bin
  typedef struct {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic [RANGE_W-1:0]      bin;
    logic                    done;
    logic                    last;
  } bin_t;

  // filter predictor and the bins it still waits for
  class pulse_comp_scoreboard;
    logic signed [SAMPLE_W-1:0] tap_re [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] tap_im [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] win_re [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] win_im [MAX_TAPS];
    bin_t bins_due[$];
    int   tap_count_r;
    int   range_len_r;
    int   line_pos;
    int   errors;
    int   bins_checked;
    int   samples_seen;
    int   taps_loaded;
    int   lines_closed;
    int   settings_written;
    int   most_bins;

    function new();
      for (int i = 0; i < MAX_TAPS; i++) begin
        tap_re[i] = '0;
        tap_im[i] = '0;
        win_re[i] = '0;
        win_im[i] = '0;
      end
      tap_count_r = int'(TAP_COUNT_RST);
      range_len_r = int'(RANGE_LEN_RST);
      line_pos = 0;
      errors = 0;
      bins_checked = 0;
      samples_seen = 0;
      taps_loaded = 0;
      lines_closed = 0;
      settings_written = 0;
      most_bins = 0;
    endfunction

    function int pending();
      return bins_due.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_CAP)
        $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void note_config(reg_idx_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_TAP_COUNT: tap_count_r = int'(v[TAP_COUNT_W-1:0]);
        REG_RANGE_LEN: range_len_r = int'(v[RANGE_W-1:0]);
        default: ;
      endcase
      settings_written++;
    endfunction

    // correlate conj(taps) against the window around bin n, newest sample at top
    function void add_bin(int n, int top, int t, bit done);
      longint acc_re;
      longint acc_im;
      int     c;
      int     pos;
      int     d;
      bin_t   b;
      acc_re = 0;
      acc_im = 0;
      c = t / 2;
      for (int m = 0; m < t; m++) begin
        pos = n + m + 1 - c;
        if (pos < 0 || pos > top) continue;
        d = top - pos;
        if (d >= MAX_TAPS) continue;
        acc_re += longint'(tap_re[m]) * longint'(win_re[d])
                + longint'(tap_im[m]) * longint'(win_im[d]);
        acc_im += longint'(tap_re[m]) * longint'(win_im[d])
                - longint'(tap_im[m]) * longint'(win_re[d]);
      end
      b.re   = acc_re[OUT_W-1:0];
      b.im   = acc_im[OUT_W-1:0];
      b.bin  = n[RANGE_W-1:0];
      b.done = done;
      b.last = 1'b0;
      bins_due.push_back(b);
    endfunction

    // advance the line by one accepted beat and queue the bins it releases
    function void note_beat(beat_t b);
      int t;
      int lag;
      int r;
      int s;
      int queued;
      queued = bins_due.size();
      if (b.kind == REQ_TAP) begin
        tap_re[b.idx] = b.re;
        tap_im[b.idx] = b.im;
        taps_loaded++;
        return;
      end
      samples_seen++;
      t = (tap_count_r < 2) ? 2 : (tap_count_r > MAX_TAPS) ? MAX_TAPS : tap_count_r;
      lag = (t - 1) / 2 + 1;
      r = (range_len_r == 0) ? 1 : range_len_r;
      s = line_pos;
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
        win_re[i] = win_re[i-1];
        win_im[i] = win_im[i-1];
      end
      win_re[0] = b.re;
      win_im[0] = b.im;
      // steady state: the bin lag samples back is complete
      if (s >= lag)
        add_bin(s - lag, s, t, 1'b0);
      // line end: flush every bin still open, then start a fresh line
      if (s + 1 >= r) begin
        for (int n = (s >= lag) ? s - lag + 1 : 0; n <= s; n++)
          add_bin(n, s, t, n == s);
        for (int i = 0; i < MAX_TAPS; i++) begin
          win_re[i] = '0;
          win_im[i] = '0;
        end
        line_pos = 0;
        lines_closed++;
      end else begin
        line_pos = (s + 1) & 16'hFFFF;
      end
      if (bins_due.size() > queued) begin
        bins_due[bins_due.size()-1].last = 1'b1;
        if (bins_due.size() - queued > most_bins)
          most_bins = bins_due.size() - queued;
      end
    endfunction

    task check_bin(bin_t got);
      bin_t want;
      if (bins_due.size() == 0) begin
        report_mismatch($sformatf("bin %0d came with nothing expected", got.bin));
        return;
      end
      want = bins_due.pop_front();
      bins_checked++;
      if (got.re !== want.re)
        report_mismatch($sformatf("bin %0d out_real %0d, want %0d", want.bin, got.re, want.re));
      if (got.im !== want.im)
        report_mismatch($sformatf("bin %0d out_imag %0d, want %0d", want.bin, got.im, want.im));
      if (got.bin !== want.bin)
        report_mismatch($sformatf("range_bin %0d, want %0d", got.bin, want.bin));
      if (got.done !== want.done)
        report_mismatch($sformatf("bin %0d line_done %b, want %b", want.bin, got.done, want.done));
      if (got.last !== want.last)
        report_mismatch($sformatf("bin %0d run_last %b, want %b", want.bin, got.last, want.last));
    endtask

    task close_out();
      if (bins_due.size() > 0)
        report_mismatch($sformatf("%0d bins never came out", bins_due.size()));
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [CFG_DATA_W-1:0]        cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         req_type_i;
  logic [TAP_IDX_W-1:0]         tap_index_i;
  logic signed [SAMPLE_W-1:0]   in_real_i;
  logic signed [SAMPLE_W-1:0]   in_imag_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [OUT_W-1:0]      out_real_o;
  logic signed [OUT_W-1:0]      out_imag_o;
  logic [RANGE_W-1:0]           range_bin_o;
  logic                         line_done_o;
  logic                         run_last_o;

  pulse_comp_scoreboard sb = new();
  int beats_sent = 0;

  radar_pulse_matched_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .tap_index_i (tap_index_i),
    .in_real_i   (in_real_i),
    .in_imag_i   (in_imag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_real_o  (out_real_o),
    .out_imag_o  (out_imag_o),
    .range_bin_o (range_bin_o),
    .line_done_o (line_done_o),
    .run_last_o  (run_last_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // hard stop for a hung run
  initial begin
    #50ms;
    $display("radar_pulse_matched_filter_test: errors");
    $finish;
  end

  // result side: random stall by phase, plus one long hold-off to back up the block
  initial begin
    int hold;
    bit held_once;
    int pct;
    hold = 0;
    held_once = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      pct = (beats_sent < PHASE_ONE_END) ? 81 : (beats_sent < PHASE_TWO_END) ? 33 : 0;
      if (!held_once && beats_sent >= HOLD_AT) begin
        held_once = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  // check every result beat taken at a rising edge
  always @(posedge clk_i) begin
    bin_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.re   = out_real_o;
      got.im   = out_imag_o;
      got.bin  = range_bin_o;
      got.done = line_done_o;
      got.last = run_last_o;
      sb.check_bin(got);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // all drive tasks start and end at a falling edge with nothing yet assigned there
  task automatic send_beat(beat_t b);
    int pct;
    pct = (beats_sent < PHASE_ONE_END) ? 33 : (beats_sent < PHASE_TWO_END) ? 81 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= b.kind;
    tap_index_i <= b.idx;
    in_real_i   <= b.re;
    in_imag_i   <= b.im;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(b);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tap(int idx, logic signed [SAMPLE_W-1:0] re,
                          logic signed [SAMPLE_W-1:0] im);
    beat_t b;
    b.kind = REQ_TAP;
    b.idx  = idx[TAP_IDX_W-1:0];
    b.re   = re;
    b.im   = im;
    send_beat(b);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] re, logic signed [SAMPLE_W-1:0] im);
    beat_t b;
    b.kind = REQ_SAMPLE;
    b.idx  = TAP_IDX_W'($urandom);
    b.re   = re;
    b.im   = im;
    send_beat(b);
  endtask

  task automatic write_reg(reg_idx_e r, logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(r, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // tap count carries junk in the unused upper data bits
  task automatic write_tap_count(int tc);
    write_reg(REG_TAP_COUNT, {(CFG_DATA_W-TAP_COUNT_W)'($urandom), TAP_COUNT_W'(tc)});
  endtask

  // wait for every expected bin, then for work that makes no bins
  task automatic settle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (sb.pending() > 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    int tap_choices [12];
    int k;
    int rl;
    int lines;
    tap_choices = '{64, 2, 127, 17, 0, 33, 1, 48, 9, 64, 3, 40};
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_TAP_COUNT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_TAP;
    tap_index_i = '0;
    in_real_i   = '0;
    in_imag_i   = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extreme taps and samples on a short three-tap line
    write_tap_count(3);
    write_reg(REG_RANGE_LEN, 16'd5);
    send_tap(0, MOST_NEG, MOST_NEG);
    send_tap(1, MOST_POS, MOST_POS);
    send_tap(2, MOST_NEG, MOST_POS);
    send_tap(MAX_TAPS - 1, MOST_POS, MOST_NEG);
    send_sample(MOST_NEG, MOST_NEG);
    send_sample(MOST_POS, MOST_POS);
    send_sample(MOST_POS, MOST_NEG);
    send_sample(MOST_NEG, MOST_POS);
    send_sample(MOST_NEG, MOST_NEG);

    // tap reload in the middle of a line takes effect at once
    send_sample(16'sd1, 16'sd2);
    send_sample(-16'sd3, 16'sd4);
    send_tap(1, -16'sd1, 16'sd1);
    send_sample(MOST_POS, -16'sd5);
    send_sample(16'sd6, MOST_NEG);
    send_sample(-16'sd7, -16'sd8);

    // one-sample lines end before the lag is reached
    settle();
    write_reg(REG_RANGE_LEN, 16'd1);
    send_sample(MOST_POS, MOST_NEG);
    send_sample(rand_word(), rand_word());

    // zero range length and tap counts below the minimum
    settle();
    write_reg(REG_RANGE_LEN, 16'd0);
    write_tap_count(0);
    send_sample(rand_word(), rand_word());
    settle();
    write_tap_count(1);
    send_sample(rand_word(), rand_word());

    // longest line cut short by lowering range_len mid-line
    settle();
    write_tap_count(2);
    write_reg(REG_RANGE_LEN, 16'hFFFF);
    repeat (4) send_sample(rand_word(), rand_word());
    settle();
    write_reg(REG_RANGE_LEN, 16'd2);
    send_sample(rand_word(), rand_word());

    // fill the whole tap store so any tap count reads written taps
    settle();
    for (int i = 0; i < MAX_TAPS; i++)
      send_tap(i, rand_word(), rand_word());

    // random settings, whole lines of random samples, some tap reloads and cut lines
    k = 0;
    while (beats_sent < TOTAL_BEATS) begin
      settle();
      rl = ($urandom_range(9) == 0) ? $urandom_range(65, 90) : $urandom_range(1, 20);
      if ($urandom_range(1)) begin
        write_tap_count(tap_choices[k % 12]);
        write_reg(REG_RANGE_LEN, CFG_DATA_W'(rl));
      end else begin
        write_reg(REG_RANGE_LEN, CFG_DATA_W'(rl));
        write_tap_count(tap_choices[k % 12]);
      end
      k++;
      lines = $urandom_range(1, 3);
      repeat (lines * rl) begin
        if (beats_sent < TOTAL_BEATS) begin
          if ($urandom_range(19) == 0)
            send_tap($urandom_range(MAX_TAPS - 1), rand_word(), rand_word());
          send_sample(rand_word(), rand_word());
        end
      end
      // leave a partial line open for the next setting to continue or cut
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, rl))
          if (beats_sent < TOTAL_BEATS)
            send_sample(rand_word(), rand_word());
    end

    settle();
    sb.close_out();
    $display("run covered %0d beats: %0d samples, %0d tap loads, %0d register writes",
             beats_sent, sb.samples_seen, sb.taps_loaded, sb.settings_written);
    $display("checked %0d bins over %0d closed lines, up to %0d bins from one beat",
             sb.bins_checked, sb.lines_closed, sb.most_bins);
    if (sb.errors == 0)
      $display("radar_pulse_matched_filter_test: clean");
    else
      $display("radar_pulse_matched_filter_test: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rpmf_pkg.sv
hw/rtl/rpmf_ram.sv
hw/rtl/rpmf_front.sv
hw/rtl/rpmf_queue.sv
hw/rtl/rpmf_back.sv
hw/rtl/radar_pulse_matched_filter.sv
dv/radar_pulse_matched_filter_test.sv
